### rtl/fesg_pkg.sv
// Shared types and constants for the filled ellipse span generator.
// Used by the config register file, the controller, the datapath and the top level.
package fesg_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd5;

	localparam int STRIDE_W = 13;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd320;
	localparam int COLOR_W = 8;

	// result field widths
	localparam int ROW_OUT_W  = 14;
	localparam int LEFT_OUT_W = 13;
	localparam int LEN_OUT_W  = 11;
	localparam int OFF_OUT_W  = 26;

	// one datapath operation per cycle
	typedef enum logic [3:0] {
		DP_NOP,
		DP_RS_LOAD,
		DP_RS_MUL,
		DP_RS_INIT,
		DP_R1_STEP,
		DP_R1_FIN,
		DP_CORR_A,
		DP_CORR_B,
		DP_R2_STEP,
		DP_R2_FIN,
		DP_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ONE  = 3'b010,
		PH_TWO  = 3'b100
	} phase_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;   // step: latch a span; R1 finish: subtract slope_y
	} cmd_t;

	typedef struct packed {
		logic sx_lt_sy;
		logic d_pos;
		logic y_neg;
		logic out_free;
	} sts_t;

endpackage

### rtl/fesg_cfg.sv
// Configuration register file of the span generator.
// Depends on fesg_pkg for register indexes and reset values.
module fesg_cfg import fesg_pkg::*; #(
	parameter int MAX_RADIUS_BITS = 10,
	parameter int COORD_BITS = 12,
	localparam int CFG_W = (COORD_BITS > STRIDE_W) ? COORD_BITS : STRIDE_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata,
	output logic [COORD_BITS-1:0]      center_x,
	output logic [COORD_BITS-1:0]      center_y,
	output logic [MAX_RADIUS_BITS-1:0] semi_axis_x,
	output logic [MAX_RADIUS_BITS-1:0] semi_axis_y,
	output logic [STRIDE_W-1:0]        row_stride,
	output logic [COLOR_W-1:0]         fill_color
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x    <= '0;
			center_y    <= '0;
			semi_axis_x <= '0;
			semi_axis_y <= '0;
			row_stride  <= STRIDE_RESET;
			fill_color  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CENTER_X:    center_x    <= cfg_wdata[COORD_BITS-1:0];
				CFG_CENTER_Y:    center_y    <= cfg_wdata[COORD_BITS-1:0];
				CFG_SEMI_AXIS_X: semi_axis_x <= cfg_wdata[MAX_RADIUS_BITS-1:0];
				CFG_SEMI_AXIS_Y: semi_axis_y <= cfg_wdata[MAX_RADIUS_BITS-1:0];
				CFG_ROW_STRIDE:  row_stride  <= cfg_wdata[STRIDE_W-1:0];
				CFG_FILL_COLOR:  fill_color  <= cfg_wdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/fesg_ctrl.sv
// Sequencing controller: input handshake, phase tracking, datapath commands.
// Depends on fesg_pkg for cmd_t, sts_t and phase_t.
module fesg_ctrl import fesg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic restart,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_WAIT = 11'b000_0000_0001,
		ST_RS1  = 11'b000_0000_0010,
		ST_RS2  = 11'b000_0000_0100,
		ST_RS3  = 11'b000_0000_1000,
		ST_R1A  = 11'b000_0001_0000,
		ST_R1B  = 11'b000_0010_0000,
		ST_CORA = 11'b000_0100_0000,
		ST_CORB = 11'b000_1000_0000,
		ST_R2A  = 11'b001_0000_0000,
		ST_R2B  = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	state_t st_q, st_d;
	phase_t phase_q, phase_d;
	logic   emit_q, emit_d;
	logic   accept;

	assign item_stall = (st_q != ST_WAIT);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		st_d     = st_q;
		phase_d  = phase_q;
		emit_d   = emit_q;
		cmd.op   = DP_NOP;
		cmd.emit = 1'b0;
		unique case (st_q)
			ST_WAIT: begin
				if (accept) begin
					if (restart) begin
						st_d = ST_RS1;
					end else begin
						unique case (phase_q)
							PH_ONE:  st_d = ST_R1A;
							PH_TWO:  st_d = ST_R2A;
							default: st_d = ST_WAIT;
						endcase
					end
				end
			end
			ST_RS1: begin
				cmd.op = DP_RS_LOAD;
				st_d   = ST_RS2;
			end
			ST_RS2: begin
				cmd.op = DP_RS_MUL;
				st_d   = ST_RS3;
			end
			ST_RS3: begin
				cmd.op  = DP_RS_INIT;
				phase_d = PH_ONE;
				st_d    = ST_WAIT;
			end
			ST_R1A: begin
				if (sts.sx_lt_sy) begin
					cmd.op   = DP_R1_STEP;
					cmd.emit = sts.d_pos;
					emit_d   = sts.d_pos;
					st_d     = ST_R1B;
				end else begin
					st_d = ST_CORA;
				end
			end
			ST_R1B: begin
				cmd.op   = DP_R1_FIN;
				cmd.emit = emit_q;
				st_d     = emit_q ? ST_OUT : ST_WAIT;
			end
			ST_CORA: begin
				cmd.op = DP_CORR_A;
				st_d   = ST_CORB;
			end
			ST_CORB: begin
				cmd.op  = DP_CORR_B;
				phase_d = PH_TWO;
				st_d    = ST_R2A;
			end
			ST_R2A: begin
				if (sts.y_neg) begin
					phase_d = PH_IDLE;
					st_d    = ST_WAIT;
				end else begin
					cmd.op   = DP_R2_STEP;
					cmd.emit = 1'b1;
					st_d     = ST_R2B;
				end
			end
			ST_R2B: begin
				cmd.op = DP_R2_FIN;
				// row counter already stepped past zero
				if (sts.y_neg) begin
					phase_d = PH_IDLE;
				end
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.op = DP_OUT;
					st_d   = ST_WAIT;
				end
			end
			default: st_d = ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_WAIT;
			phase_q <= PH_IDLE;
			emit_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			emit_q  <= emit_d;
		end
	end

endmodule

### rtl/fesg_dp.sv
// Datapath: latched setup, midpoint decision terms, span latch and output register.
// Depends on fesg_pkg for cmd_t, sts_t and field widths.
module fesg_dp import fesg_pkg::*; #(
	parameter int MAX_RADIUS_BITS = 10,
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic [COORD_BITS-1:0]         center_x,
	input  logic [COORD_BITS-1:0]         center_y,
	input  logic [MAX_RADIUS_BITS-1:0]    semi_axis_x,
	input  logic [MAX_RADIUS_BITS-1:0]    semi_axis_y,
	input  logic [STRIDE_W-1:0]           row_stride,
	input  logic [COLOR_W-1:0]            fill_color,
	output logic                          span_valid,
	input  logic                          span_stall,
	output logic signed [ROW_OUT_W-1:0]   upper_row,
	output logic signed [ROW_OUT_W-1:0]   lower_row,
	output logic signed [LEFT_OUT_W-1:0]  span_left,
	output logic [LEN_OUT_W-1:0]          span_length,
	output logic signed [OFF_OUT_W-1:0]   upper_offset,
	output logic signed [OFF_OUT_W-1:0]   lower_offset,
	output logic [COLOR_W-1:0]            span_color,
	output logic                          last
);

	localparam int R   = MAX_RADIUS_BITS;
	localparam int XW  = R + 1;
	localparam int YW  = R + 2;
	localparam int A2W = 2 * R;
	localparam int PW  = 3 * R;
	localparam int SW  = 3 * R + 4;
	localparam int DW  = 3 * R + 10;
	localparam int RW  = ((COORD_BITS > R) ? COORD_BITS : R) + 3;
	localparam int MW  = (RW + STRIDE_W + 2 > OFF_OUT_W) ? RW + STRIDE_W + 2 : OFF_OUT_W;

	// latched setup
	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [COLOR_W-1:0]    color_q;
	logic [R-1:0]          b_q;
	logic [A2W-1:0]        a2_q, b2_q;
	logic [A2W+1:0]        b2x3_q;
	logic [PW-1:0]         a2b_q;
	logic signed [SW-1:0]  k3h_q;

	// iteration state
	logic [XW-1:0]         x_q;
	logic signed [YW-1:0]  y_q;
	logic signed [SW-1:0]  sx_q, sy_q, t_q;
	logic signed [DW-1:0]  d_q;
	logic                  neg_q;

	// span latched at the step, expanded into offsets on output
	logic signed [RW-1:0]  up_q, lo_q, left_q;
	logic [LEN_OUT_W-1:0]  len_q;
	logic                  last_q;

	logic signed [SW-1:0]  two_a2, two_b2;
	logic signed [SW-1:0]  k3_diff, k3, k3_adj, k3_half;
	logic signed [SW-1:0]  t_adj, t_half;
	logic signed [MW-1:0]  stride_x, up_off, lo_off;

	assign two_a2 = SW'({a2_q, 1'b0});
	assign two_b2 = SW'({b2_q, 1'b0});

	// C-style halving: bias negatives by one before the arithmetic shift
	assign k3_diff = SW'(a2_q) - SW'(b2_q);
	assign k3      = k3_diff + (k3_diff <<< 1);
	assign k3_adj  = k3 + SW'(k3[SW-1]);
	assign k3_half = k3_adj >>> 1;
	assign t_adj   = t_q + SW'(t_q[SW-1]);
	assign t_half  = t_adj >>> 1;

	assign stride_x = MW'($signed({1'b0, stride_q}));
	assign up_off   = MW'(up_q) * stride_x + MW'(left_q);
	assign lo_off   = MW'(lo_q) * stride_x + MW'(left_q);

	assign sts.sx_lt_sy = (sx_q < sy_q);
	assign sts.d_pos    = !d_q[DW-1] && (d_q != '0);
	assign sts.y_neg    = y_q[YW-1];
	assign sts.out_free = !span_valid || !span_stall;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_RS_LOAD: begin
				cx_q     <= center_x;
				cy_q     <= center_y;
				stride_q <= row_stride;
				color_q  <= fill_color;
				b_q      <= semi_axis_y;
				a2_q     <= A2W'(semi_axis_x) * A2W'(semi_axis_x);
				b2_q     <= A2W'(semi_axis_y) * A2W'(semi_axis_y);
				x_q      <= '0;
				y_q      <= YW'(semi_axis_y);
				sx_q     <= '0;
			end
			DP_RS_MUL: begin
				a2b_q  <= PW'(a2_q) * PW'(b_q);
				b2x3_q <= (A2W+2)'({b2_q, 1'b0}) + (A2W+2)'(b2_q);
				k3h_q  <= k3_half;
			end
			DP_RS_INIT: begin
				sy_q <= SW'({a2b_q, 1'b0});
				d_q  <= DW'(b2_q) - DW'(a2b_q) + DW'(a2_q >> 2);
			end
			DP_R1_STEP: begin
				if (cmd.emit) begin
					up_q   <= RW'(cy_q) - RW'(y_q);
					lo_q   <= RW'(cy_q) + RW'(y_q);
					left_q <= RW'(cx_q) - RW'(x_q);
					len_q  <= LEN_OUT_W'({x_q, 1'b0});
					last_q <= 1'b0;
					y_q    <= y_q - YW'(1);
					sy_q   <= sy_q - two_a2;
				end
			end
			DP_R1_FIN: begin
				// slope_y here is already the stepped value
				d_q  <= d_q - (cmd.emit ? DW'(sy_q) : DW'(0)) + DW'(sx_q) + DW'(b2x3_q);
				sx_q <= sx_q + two_b2;
				x_q  <= x_q + XW'(1);
			end
			DP_CORR_A: begin
				t_q <= k3h_q - (sx_q + sy_q);
			end
			DP_CORR_B: begin
				d_q <= d_q + DW'(t_half);
			end
			DP_R2_STEP: begin
				up_q   <= RW'(cy_q) - RW'(y_q);
				lo_q   <= RW'(cy_q) + RW'(y_q);
				left_q <= RW'(cx_q) - RW'(x_q);
				len_q  <= LEN_OUT_W'({x_q, 1'b0});
				last_q <= (y_q == '0);
				y_q    <= y_q - YW'(1);
				sy_q   <= sy_q - two_a2;
				neg_q  <= d_q[DW-1];
				if (d_q[DW-1]) begin
					x_q  <= x_q + XW'(1);
					sx_q <= sx_q + two_b2;
				end
			end
			DP_R2_FIN: begin
				d_q <= d_q + (neg_q ? DW'(sx_q) : DW'(0)) + DW'(a2_q) - DW'(sy_q);
			end
			DP_OUT: begin
				upper_row    <= ROW_OUT_W'(up_q);
				lower_row    <= ROW_OUT_W'(lo_q);
				span_left    <= LEFT_OUT_W'(left_q);
				span_length  <= len_q;
				upper_offset <= OFF_OUT_W'(up_off);
				lower_offset <= OFF_OUT_W'(lo_off);
				span_color   <= color_q;
				last         <= last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid <= 1'b0;
		end else if (cmd.op == DP_OUT) begin
			span_valid <= 1'b1;
		end else if (!span_stall) begin
			span_valid <= 1'b0;
		end
	end

endmodule

### rtl/filled_ellipse_span_generator.sv
// Top level of the filled ellipse span generator (stepped midpoint ellipse).
// Instantiates fesg_cfg, fesg_ctrl and fesg_dp; depends on fesg_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  config   | cfg_wr_en              | cfg_index, cfg_wdata
//  item     | item_valid/item_stall  | restart
//  span     | span_valid/span_stall  | upper_row, lower_row, span_left, span_length,
//           |                        | upper_offset, lower_offset, span_color, last
//
// Restart: accept, then the setup states RS1 (load and squares), RS2 (radius products) and RS3 (initial terms).
// Region-one step: R1A and R1B, then OUT when it yields a span; the region change adds CORA and CORB.
// Region-two step: R2A, R2B, then OUT. Each step is a short sequence of datapath operations.
// The span register holds a result under span_stall while the next item is taken;
// a new span waits only while that register is full and span_stall is high.
// Reset clears configuration (stride 320) and leaves no ellipse active.
module filled_ellipse_span_generator import fesg_pkg::*; #(
	parameter int MAX_RADIUS_BITS = 10,
	parameter int COORD_BITS = 12,
	localparam int CFG_W = (COORD_BITS > STRIDE_W) ? COORD_BITS : STRIDE_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_wdata,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         restart,
	output logic                         span_valid,
	input  logic                         span_stall,
	output logic signed [ROW_OUT_W-1:0]  upper_row,
	output logic signed [ROW_OUT_W-1:0]  lower_row,
	output logic signed [LEFT_OUT_W-1:0] span_left,
	output logic [LEN_OUT_W-1:0]         span_length,
	output logic signed [OFF_OUT_W-1:0]  upper_offset,
	output logic signed [OFF_OUT_W-1:0]  lower_offset,
	output logic [COLOR_W-1:0]           span_color,
	output logic                         last
);

	logic [COORD_BITS-1:0]      center_x, center_y;
	logic [MAX_RADIUS_BITS-1:0] semi_axis_x, semi_axis_y;
	logic [STRIDE_W-1:0]        row_stride;
	logic [COLOR_W-1:0]         fill_color;
	cmd_t                       cmd;
	sts_t                       sts;

	fesg_cfg #(
		.MAX_RADIUS_BITS(MAX_RADIUS_BITS),
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.center_x(center_x),
		.center_y(center_y),
		.semi_axis_x(semi_axis_x),
		.semi_axis_y(semi_axis_y),
		.row_stride(row_stride),
		.fill_color(fill_color)
	);

	fesg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.restart(restart),
		.sts(sts),
		.cmd(cmd)
	);

	fesg_dp #(
		.MAX_RADIUS_BITS(MAX_RADIUS_BITS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.center_x(center_x),
		.center_y(center_y),
		.semi_axis_x(semi_axis_x),
		.semi_axis_y(semi_axis_y),
		.row_stride(row_stride),
		.fill_color(fill_color),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.upper_row(upper_row),
		.lower_row(lower_row),
		.span_left(span_left),
		.span_length(span_length),
		.upper_offset(upper_offset),
		.lower_offset(lower_offset),
		.span_color(span_color),
		.last(last)
	);

endmodule

### bench/fesg_span_checker.sv
// Span scoreboard for filled_ellipse_span_generator: mirrors the config registers,
// predicts the span pair (if any) of every accepted item and compares accepted spans.
// Depends on fesg_pkg.
module fesg_span_checker import fesg_pkg::*; #(
	parameter int MAX_RADIUS_BITS = 10,
	parameter int COORD_BITS = 12,
	parameter int CFG_W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_wdata,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  logic                         restart,
	input  logic                         span_valid,
	input  logic                         span_stall,
	input  logic signed [ROW_OUT_W-1:0]  upper_row,
	input  logic signed [ROW_OUT_W-1:0]  lower_row,
	input  logic signed [LEFT_OUT_W-1:0] span_left,
	input  logic [LEN_OUT_W-1:0]         span_length,
	input  logic signed [OFF_OUT_W-1:0]  upper_offset,
	input  logic signed [OFF_OUT_W-1:0]  lower_offset,
	input  logic [COLOR_W-1:0]           span_color,
	input  logic                         last,
	output int                           fails,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [63:0] wide_t;

	typedef struct packed {
		logic signed [ROW_OUT_W-1:0]  up_row;
		logic signed [ROW_OUT_W-1:0]  lo_row;
		logic signed [LEFT_OUT_W-1:0] left;
		logic [LEN_OUT_W-1:0]         len;
		logic signed [OFF_OUT_W-1:0]  up_off;
		logic signed [OFF_OUT_W-1:0]  lo_off;
		logic [COLOR_W-1:0]           color;
		logic                         fin;
	} span_t;

	// register mirror
	logic [COORD_BITS-1:0]      reg_cx, reg_cy;
	logic [MAX_RADIUS_BITS-1:0] reg_a, reg_b;
	logic [STRIDE_W-1:0]        reg_stride;
	logic [COLOR_W-1:0]         reg_color;

	// copy taken at restart
	wide_t              cx, cy, stride, a_sq, b_sq;
	logic [COLOR_W-1:0] color;

	// rasterizer state
	phase_t phase;
	wide_t  px, py, slope_x, slope_y, decision;

	span_t spans_due[$];
	int    span_count;

	task automatic report(input string msg);
		if (fails < 60)
			$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	function automatic span_t pair_at(input logic fin);
		span_t s;
		wide_t up, lo, left, len2, up_off, lo_off;
		up = cy - py;
		lo = cy + py;
		left = cx - px;
		len2 = 2 * px;
		up_off = up * stride + left;
		lo_off = lo * stride + left;
		s.up_row = up[ROW_OUT_W-1:0];
		s.lo_row = lo[ROW_OUT_W-1:0];
		s.left = left[LEFT_OUT_W-1:0];
		s.len = len2[LEN_OUT_W-1:0];
		s.up_off = up_off[OFF_OUT_W-1:0];
		s.lo_off = lo_off[OFF_OUT_W-1:0];
		s.color = color;
		s.fin = fin;
		return s;
	endfunction

	// one midpoint iteration (or a reload) per accepted item
	task automatic advance_rasterizer(input logic reload);
		wide_t a, b;
		logic stepped;
		a = wide_t'(reg_a);
		b = wide_t'(reg_b);
		stepped = 1'b0;
		if (reload) begin
			cx = wide_t'(reg_cx);
			cy = wide_t'(reg_cy);
			stride = wide_t'(reg_stride);
			color = reg_color;
			a_sq = a * a;
			b_sq = b * b;
			px = 0;
			py = b;
			slope_x = 0;
			slope_y = 2 * a_sq * b;
			decision = b_sq - a_sq * b + a_sq / 4;
			phase = PH_ONE;
			return;
		end
		if (phase == PH_ONE) begin
			if (slope_x < slope_y) begin
				if (decision > 0) begin
					spans_due.push_back(pair_at(1'b0));
					py = py - 1;
					slope_y = slope_y - 2 * a_sq;
					decision = decision - slope_y;
				end
				px = px + 1;
				slope_x = slope_x + 2 * b_sq;
				decision = decision + slope_x + b_sq;
				stepped = 1'b1;
			end else begin
				// region change; the first region-two iteration follows in this step
				decision = decision + ((3 * (a_sq - b_sq)) / 2 - (slope_x + slope_y)) / 2;
				phase = PH_TWO;
			end
		end
		if (!stepped && phase == PH_TWO) begin
			if (py < 0) begin
				phase = PH_IDLE;
			end else begin
				spans_due.push_back(pair_at(py == 0));
				py = py - 1;
				if (decision < 0) begin
					px = px + 1;
					slope_x = slope_x + 2 * b_sq;
					decision = decision + slope_x;
				end
				slope_y = slope_y - 2 * a_sq;
				decision = decision + a_sq - slope_y;
				if (py < 0)
					phase = PH_IDLE;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_t got, want;
		if (!arst_n) begin
			reg_cx = '0;
			reg_cy = '0;
			reg_a = '0;
			reg_b = '0;
			reg_stride = STRIDE_RESET;
			reg_color = '0;
			cx = 0;
			cy = 0;
			stride = 320;
			a_sq = 0;
			b_sq = 0;
			color = '0;
			phase = PH_IDLE;
			px = 0;
			py = 0;
			slope_x = 0;
			slope_y = 0;
			decision = 0;
			spans_due.delete();
			span_count = 0;
			fails = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CENTER_X:    reg_cx = cfg_wdata[COORD_BITS-1:0];
					CFG_CENTER_Y:    reg_cy = cfg_wdata[COORD_BITS-1:0];
					CFG_SEMI_AXIS_X: reg_a = cfg_wdata[MAX_RADIUS_BITS-1:0];
					CFG_SEMI_AXIS_Y: reg_b = cfg_wdata[MAX_RADIUS_BITS-1:0];
					CFG_ROW_STRIDE:  reg_stride = cfg_wdata[STRIDE_W-1:0];
					CFG_FILL_COLOR:  reg_color = cfg_wdata[COLOR_W-1:0];
					default: ;
				endcase
			end
			if (span_valid && !span_stall) begin
				got.up_row = upper_row;
				got.lo_row = lower_row;
				got.left = span_left;
				got.len = span_length;
				got.up_off = upper_offset;
				got.lo_off = lower_offset;
				got.color = span_color;
				got.fin = last;
				if (spans_due.size() == 0) begin
					report($sformatf("span %0d: transaction with no span predicted", span_count));
				end else begin
					want = spans_due.pop_front();
					if (got.up_row !== want.up_row)
						report($sformatf("span %0d: upper_row %0d, predicted %0d",
							span_count, got.up_row, want.up_row));
					if (got.lo_row !== want.lo_row)
						report($sformatf("span %0d: lower_row %0d, predicted %0d",
							span_count, got.lo_row, want.lo_row));
					if (got.left !== want.left)
						report($sformatf("span %0d: span_left %0d, predicted %0d",
							span_count, got.left, want.left));
					if (got.len !== want.len)
						report($sformatf("span %0d: span_length %0d, predicted %0d",
							span_count, got.len, want.len));
					if (got.up_off !== want.up_off)
						report($sformatf("span %0d: upper_offset %0d, predicted %0d",
							span_count, got.up_off, want.up_off));
					if (got.lo_off !== want.lo_off)
						report($sformatf("span %0d: lower_offset %0d, predicted %0d",
							span_count, got.lo_off, want.lo_off));
					if (got.color !== want.color)
						report($sformatf("span %0d: span_color %0d, predicted %0d",
							span_count, got.color, want.color));
					if (got.fin !== want.fin)
						report($sformatf("span %0d: last %0b, predicted %0b",
							span_count, got.fin, want.fin));
				end
				span_count++;
			end
			if (item_valid && !item_stall)
				advance_rasterizer(restart);
		end
		pending = spans_due.size();
	end

endmodule

### bench/tb_filled_ellipse_span_generator.sv
// Stimulus top for filled_ellipse_span_generator: clock, reset, register writes,
// restart/step transactions and span back-pressure; fesg_span_checker does the checking.
// Depends on fesg_pkg, the RTL top and bench/fesg_span_checker.sv.
module tb_filled_ellipse_span_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import fesg_pkg::*;

	localparam int MAX_RADIUS_BITS = 10;
	localparam int COORD_BITS = 12;
	localparam int CFG_W = (COORD_BITS > STRIDE_W) ? COORD_BITS : STRIDE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int ITEM_GOAL = 1725;
	localparam int QUIET_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam longint LIMIT_NS = 64'd20_000_000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]             cfg_wdata;
	logic                         item_valid;
	logic                         item_stall;
	logic                         restart;
	logic                         span_valid;
	logic                         span_stall;
	logic signed [ROW_OUT_W-1:0]  upper_row;
	logic signed [ROW_OUT_W-1:0]  lower_row;
	logic signed [LEFT_OUT_W-1:0] span_left;
	logic [LEN_OUT_W-1:0]         span_length;
	logic signed [OFF_OUT_W-1:0]  upper_offset;
	logic signed [OFF_OUT_W-1:0]  lower_offset;
	logic [COLOR_W-1:0]           span_color;
	logic                         last;

	int fails, pending;
	int items_sent;
	int hold_requests, holds_served;
	int reg_a, reg_b;
	bit steady;

	filled_ellipse_span_generator #(
		.MAX_RADIUS_BITS(MAX_RADIUS_BITS),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.restart(restart),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.upper_row(upper_row),
		.lower_row(lower_row),
		.span_left(span_left),
		.span_length(span_length),
		.upper_offset(upper_offset),
		.lower_offset(lower_offset),
		.span_color(span_color),
		.last(last)
	);

	fesg_span_checker #(
		.MAX_RADIUS_BITS(MAX_RADIUS_BITS),
		.COORD_BITS(COORD_BITS),
		.CFG_W(CFG_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.restart(restart),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.upper_row(upper_row),
		.lower_row(lower_row),
		.span_left(span_left),
		.span_length(span_length),
		.upper_offset(upper_offset),
		.lower_offset(lower_offset),
		.span_color(span_color),
		.last(last),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("filled_ellipse_span_generator: mismatch");
		$finish;
	end

	// span receiver: stall pattern changes per segment, plus requested long hold-offs
	initial begin
		int seg, mode, hold_left;
		span_stall = 1'b0;
		holds_served = 0;
		hold_left = 0;
		forever begin
			seg = $urandom_range(16, 128);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				@(negedge clk);
				if (hold_left == 0 && holds_served != hold_requests) begin
					holds_served++;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					span_stall = 1'b1;
					hold_left--;
				end else begin
					case (mode)
						0: span_stall = 1'b0;
						1: span_stall = ($urandom_range(0, 3) == 0);
						2: span_stall = ($urandom_range(0, 3) != 0);
						default: span_stall = ~span_stall;
					endcase
				end
			end
		end
	end

	task automatic send_item(input logic reload);
		@(negedge clk);
		item_valid = 1'b1;
		restart = reload;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			item_valid = 1'b0;
			restart = 1'($urandom_range(0, 1));
		end
	endtask

	task automatic feed_steps(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && count > 0) begin
				send_item(1'b0);
				burst--;
				count--;
			end
			if (!steady && $urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 6));
		end
	endtask

	// sender stops until every predicted span is out and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		if (idx == CFG_SEMI_AXIS_X)
			reg_a = int'(data[MAX_RADIUS_BITS-1:0]);
		if (idx == CFG_SEMI_AXIS_Y)
			reg_b = int'(data[MAX_RADIUS_BITS-1:0]);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic int pick_radius();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 10);
		if (r < 88)
			return $urandom_range(11, 40);
		if (r < 95)
			return $urandom_range(41, 120);
		case ($urandom_range(0, 2))
			0: return 1023;
			1: return 512;
			default: return $urandom_range(121, 1023);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(4095);
			2: return '1;
			default: return CFG_W'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_stride();
		case ($urandom_range(0, 11))
			0: return CFG_W'(1);
			1: return CFG_W'(4096);
			2: return '0;
			3: return '1;
			default: return CFG_W'($urandom_range(1, 4096));
		endcase
	endfunction

	task automatic new_setup(input int a, input int b);
		logic [CFG_W-1:0] d;
		settle();
		d = CFG_W'($urandom_range(0, 8191));
		d[MAX_RADIUS_BITS-1:0] = MAX_RADIUS_BITS'(a);
		write_reg(CFG_SEMI_AXIS_X, d);
		d = CFG_W'($urandom_range(0, 8191));
		d[MAX_RADIUS_BITS-1:0] = MAX_RADIUS_BITS'(b);
		write_reg(CFG_SEMI_AXIS_Y, d);
		if ($urandom_range(0, 1))
			write_reg(CFG_CENTER_X, pick_coord());
		if ($urandom_range(0, 1))
			write_reg(CFG_CENTER_Y, pick_coord());
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_ROW_STRIDE, pick_stride());
		if ($urandom_range(0, 1))
			write_reg(CFG_FILL_COLOR, CFG_W'($urandom_range(0, 8191)));
		if ($urandom_range(0, 7) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				CFG_W'($urandom_range(0, 8191)));
		end_writes();
	endtask

	initial begin
		int n, cut, total, directed_end;
		bit broken, big;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		restart = 1'b0;
		items_sent = 0;
		hold_requests = 0;
		reg_a = 0;
		reg_b = 0;
		steady = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// step with no ellipse active is dropped
		send_item(1'b0);
		// reset configuration: both radii zero, one empty span
		send_item(1'b1);
		feed_steps(2);

		settle();
		write_reg(CFG_CENTER_X, CFG_W'(4095));
		write_reg(CFG_CENTER_Y, CFG_W'(4095));
		write_reg(CFG_SEMI_AXIS_X, '0);
		write_reg(CFG_SEMI_AXIS_Y, CFG_W'(3));
		write_reg(CFG_ROW_STRIDE, '1);
		write_reg(CFG_FILL_COLOR, CFG_W'(255));
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '1);
		end_writes();
		send_item(1'b1);
		feed_steps(5);

		// zero half-height, stride of zero, radius written with junk high bits
		settle();
		write_reg(CFG_CENTER_X, '0);
		write_reg(CFG_CENTER_Y, '0);
		write_reg(CFG_SEMI_AXIS_X, CFG_W'(13'h1C03));
		write_reg(CFG_SEMI_AXIS_Y, '0);
		write_reg(CFG_ROW_STRIDE, '0);
		write_reg(CFG_FILL_COLOR, '0);
		end_writes();
		send_item(1'b1);
		feed_steps(3);

		// restart while an ellipse is active, then register writes mid-ellipse
		settle();
		write_reg(CFG_SEMI_AXIS_X, CFG_W'(3));
		write_reg(CFG_SEMI_AXIS_Y, CFG_W'(2));
		write_reg(CFG_ROW_STRIDE, CFG_W'(1));
		write_reg(CFG_FILL_COLOR, CFG_W'(8'h5A));
		end_writes();
		send_item(1'b1);
		feed_steps(2);
		send_item(1'b1);
		feed_steps(2);
		settle();
		write_reg(CFG_FILL_COLOR, CFG_W'(8'hA5));
		write_reg(CFG_SEMI_AXIS_Y, CFG_W'(9));
		end_writes();
		feed_steps(5);
		directed_end = items_sent;

		while (items_sent < ITEM_GOAL) begin
			if (items_sent == directed_end || $urandom_range(0, 1))
				new_setup(pick_radius(), pick_radius());
			big = (reg_a > 120 || reg_b > 120);
			total = reg_a + reg_b + 2;
			broken = big || ($urandom_range(0, 4) == 0);
			if (broken)
				n = $urandom_range(0, big ? 40 : total);
			else
				n = total + $urandom_range(0, 2);
			steady = ($urandom_range(0, 3) == 0);
			send_item(1'b1);
			// long receiver hold-off while steps keep coming
			if (!broken && reg_b >= 16 && hold_requests < 2)
				hold_requests++;
			if (n > 4 && $urandom_range(0, 9) == 0) begin
				cut = n / 2;
				feed_steps(cut);
				settle();
				write_reg(CFG_IDX_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 8191)));
				end_writes();
				feed_steps(n - cut);
			end else begin
				feed_steps(n);
			end
		end

		settle();
		if (fails == 0)
			$display("filled_ellipse_span_generator: match");
		else
			$display("filled_ellipse_span_generator: mismatch");
		$finish;
	end

endmodule
